>>> rtl/ghal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghal_pkg
// shared types and constants of the generational handle allocator
// ----------------------------------------------------------------------------
package ghal_pkg;

    localparam int SLOTS     = 256;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int HW_W      = IDX_W + 1;
    localparam int VER_W     = 16;
    localparam int TAG_W     = 2;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 2;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = STAT_W;
    localparam int M_PAD_W   = M_TDATA_W - IDX_W - VER_W - 1 - HW_W;

    localparam logic [TAG_W-1:0] TAG_NONE = '0;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 3'd0,
        OP_TAG    = 3'd1,
        OP_SWEEP  = 3'd2,
        OP_ACT    = 3'd3,
        OP_DEACT  = 3'd4,
        OP_QUERY  = 3'd5
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_STALE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_EXEC,
        S_SWEEP,
        S_SDONE
    } t_state;

    // one slot table entry
    typedef struct packed {
        logic [VER_W-1:0] version;
        logic             active;
        logic [TAG_W-1:0] tag;
    } t_slot;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic pop;
        logic exec;
        logic sweep_run;
        logic sweep_done;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic stack_empty;
        logic sweep_end;
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/ghal_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghal_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module ghal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ghal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghal_ctrl
// sequencer of the allocator: one operation at a time
// ----------------------------------------------------------------------------
module ghal_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  ghal_pkg::t_op                     i_op,
    input  ghal_pkg::t_dp_stat                i_stat,
    output logic                              o_s_tready,
    output ghal_pkg::t_cmd                    o_cmd
);

    ghal_pkg::t_state r_state;
    ghal_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ghal_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ghal_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    priority if (i_op == ghal_pkg::OP_ALLOC && !i_stat.stack_empty) begin
                        n_state = ghal_pkg::S_POP;
                    end else if (i_op == ghal_pkg::OP_SWEEP) begin
                        n_state = ghal_pkg::S_SWEEP;
                    end else begin
                        n_state = ghal_pkg::S_EXEC;
                    end
                end
            end
            ghal_pkg::S_POP: begin
                n_state = ghal_pkg::S_EXEC;
            end
            ghal_pkg::S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = ghal_pkg::S_IDLE;
                end
            end
            ghal_pkg::S_SWEEP: begin
                if (i_stat.sweep_end) begin
                    n_state = ghal_pkg::S_SDONE;
                end
            end
            ghal_pkg::S_SDONE: begin
                if (i_stat.out_free) begin
                    n_state = ghal_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ghal_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_s_tready       = 1'b0;
        unique case (r_state)
            ghal_pkg::S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            ghal_pkg::S_POP: begin
                o_cmd.pop = 1'b1;
            end
            ghal_pkg::S_EXEC: begin
                o_cmd.exec = i_stat.out_free;
            end
            ghal_pkg::S_SWEEP: begin
                o_cmd.sweep_run = 1'b1;
            end
            ghal_pkg::S_SDONE: begin
                o_cmd.sweep_done = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/ghal_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghal_dp
// slot table, free stack, live bits, counters and the result register
// ----------------------------------------------------------------------------
module ghal_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [ghal_pkg::S_TDATA_W-1:0]      i_s_tdata,
    input  logic [ghal_pkg::S_TUSER_W-1:0]      i_s_tuser,
    input  ghal_pkg::t_cmd                      i_cmd,
    input  logic                                i_m_tready,
    output ghal_pkg::t_dp_stat                  o_stat,
    output logic                                o_m_tvalid,
    output logic [ghal_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic [ghal_pkg::M_TUSER_W-1:0]      o_m_tuser
);

    // input word fields
    ghal_pkg::t_op                in_op;
    logic                         in_act;
    logic [ghal_pkg::HW_W-1:0]    in_idx;
    logic [ghal_pkg::VER_W-1:0]   in_ver;
    logic [ghal_pkg::TAG_W-1:0]   in_kind;

    assign in_op   = ghal_pkg::t_op'(i_s_tuser[ghal_pkg::OP_W-1:0]);
    assign in_act  = i_s_tdata[0];
    assign in_idx  = i_s_tdata[ghal_pkg::HW_W:1];
    assign in_ver  = i_s_tdata[ghal_pkg::HW_W+ghal_pkg::VER_W:ghal_pkg::HW_W+1];
    assign in_kind = i_s_tdata[ghal_pkg::HW_W+ghal_pkg::VER_W+ghal_pkg::TAG_W:
                               ghal_pkg::HW_W+ghal_pkg::VER_W+1];

    // control state
    logic [ghal_pkg::HW_W-1:0]    r_hw, n_hw;
    logic [ghal_pkg::HW_W-1:0]    r_fc, n_fc;
    logic [ghal_pkg::HW_W-1:0]    r_cnt, n_cnt;
    logic [ghal_pkg::HW_W-1:0]    r_freed, n_freed;
    logic [ghal_pkg::SLOTS-1:0]   r_live, n_live;
    logic                         r_sw_v;
    logic                         r_m_valid;

    // latched item and scratch
    ghal_pkg::t_op                r_op;
    logic                         r_act;
    logic [ghal_pkg::HW_W-1:0]    r_idx;
    logic [ghal_pkg::VER_W-1:0]   r_ver;
    logic [ghal_pkg::TAG_W-1:0]   r_kind;
    logic                         r_idx_ok;
    logic                         r_from_stack;
    logic                         r_full;
    logic [ghal_pkg::IDX_W-1:0]   r_s;
    logic [ghal_pkg::IDX_W-1:0]   r_raddr;
    logic [ghal_pkg::IDX_W-1:0]   r_sw_idx;
    logic [ghal_pkg::M_TDATA_W-1:0] r_m_data;
    logic [ghal_pkg::M_TUSER_W-1:0] r_m_user;

    // memory ports
    logic                         slot_we;
    logic [ghal_pkg::IDX_W-1:0]   slot_waddr;
    ghal_pkg::t_slot              slot_wdata;
    logic [ghal_pkg::IDX_W-1:0]   slot_raddr;
    ghal_pkg::t_slot              slot_rdata;
    logic                         stk_we;
    logic [ghal_pkg::IDX_W-1:0]   stk_waddr;
    logic [ghal_pkg::IDX_W-1:0]   stk_wdata;
    logic [ghal_pkg::HW_W-1:0]    stk_rptr;
    logic [ghal_pkg::IDX_W-1:0]   stk_rdata;

    // result
    logic                         load;
    logic                         out_free;
    logic                         handle_ok;
    logic                         sw_issue;
    logic                         sw_free;
    logic [ghal_pkg::VER_W-1:0]   alloc_ver;
    logic [ghal_pkg::IDX_W-1:0]   res_index;
    logic [ghal_pkg::VER_W-1:0]   res_version;
    ghal_pkg::t_status            res_status;
    logic                         res_active;
    logic [ghal_pkg::HW_W-1:0]    res_freed;

    ghal_ram #(
        .WIDTH ($bits(ghal_pkg::t_slot)),
        .DEPTH (ghal_pkg::SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    assign stk_rptr = r_fc - ghal_pkg::HW_W'(1);

    ghal_ram #(
        .WIDTH (ghal_pkg::IDX_W),
        .DEPTH (ghal_pkg::SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_rptr[ghal_pkg::IDX_W-1:0]),
        .o_rdata (stk_rdata)
    );

    assign out_free  = !r_m_valid || i_m_tready;
    assign handle_ok = r_idx_ok && r_live[r_idx[ghal_pkg::IDX_W-1:0]]
                       && (slot_rdata.version == r_ver);

    always_comb begin
        n_hw        = r_hw;
        n_fc        = r_fc;
        n_cnt       = r_cnt;
        n_freed     = r_freed;
        n_live      = r_live;
        slot_we     = 1'b0;
        slot_waddr  = r_raddr;
        slot_wdata  = slot_rdata;
        slot_raddr  = r_raddr;
        stk_we      = 1'b0;
        stk_waddr   = r_fc[ghal_pkg::IDX_W-1:0];
        stk_wdata   = r_sw_idx;
        sw_issue    = 1'b0;
        sw_free     = 1'b0;
        load        = 1'b0;
        alloc_ver   = '0;
        res_index   = '0;
        res_version = '0;
        res_status  = ghal_pkg::ST_OK;
        res_active  = 1'b0;
        res_freed   = '0;

        if (i_cmd.accept) begin
            slot_raddr = in_idx[ghal_pkg::IDX_W-1:0];
            n_cnt      = '0;
            n_freed    = '0;
        end

        if (i_cmd.pop) begin
            slot_raddr = stk_rdata;
        end

        // sweep: read stage on r_cnt, free stage one slot behind
        if (i_cmd.sweep_run) begin
            if (r_cnt < r_hw) begin
                sw_issue   = 1'b1;
                slot_raddr = r_cnt[ghal_pkg::IDX_W-1:0];
                n_cnt      = r_cnt + ghal_pkg::HW_W'(1);
            end
            if (r_sw_v && r_live[r_sw_idx] && slot_rdata.tag != ghal_pkg::TAG_NONE) begin
                sw_free            = 1'b1;
                slot_we            = 1'b1;
                slot_waddr         = r_sw_idx;
                slot_wdata.version = slot_rdata.version + ghal_pkg::VER_W'(1);
                slot_wdata.active  = slot_rdata.active;
                slot_wdata.tag     = ghal_pkg::TAG_NONE;
                n_live[r_sw_idx]   = 1'b0;
                stk_we             = 1'b1;
                n_fc               = r_fc + ghal_pkg::HW_W'(1);
                n_freed            = r_freed + ghal_pkg::HW_W'(1);
            end
        end

        if (i_cmd.exec) begin
            load = 1'b1;
            unique case (r_op)
                ghal_pkg::OP_ALLOC: begin
                    if (r_full) begin
                        res_status = ghal_pkg::ST_FULL;
                    end else begin
                        if (r_from_stack) begin
                            alloc_ver = slot_rdata.version;
                            n_fc      = r_fc - ghal_pkg::HW_W'(1);
                        end else begin
                            alloc_ver = '0;
                            n_hw      = r_hw + ghal_pkg::HW_W'(1);
                        end
                        slot_we            = 1'b1;
                        slot_waddr         = r_s;
                        slot_wdata.version = alloc_ver;
                        slot_wdata.active  = r_act;
                        slot_wdata.tag     = ghal_pkg::TAG_NONE;
                        n_live[r_s]        = 1'b1;
                        res_index          = r_s;
                        res_version        = alloc_ver;
                    end
                end
                ghal_pkg::OP_TAG: begin
                    if (handle_ok) begin
                        slot_we        = 1'b1;
                        slot_waddr     = r_idx[ghal_pkg::IDX_W-1:0];
                        slot_wdata.tag = r_kind;
                    end else begin
                        res_status = ghal_pkg::ST_STALE;
                    end
                end
                ghal_pkg::OP_ACT, ghal_pkg::OP_DEACT: begin
                    if (handle_ok) begin
                        slot_we           = 1'b1;
                        slot_waddr        = r_idx[ghal_pkg::IDX_W-1:0];
                        slot_wdata.active = (r_op == ghal_pkg::OP_ACT);
                    end else begin
                        res_status = ghal_pkg::ST_STALE;
                    end
                end
                ghal_pkg::OP_QUERY: begin
                    if (handle_ok) begin
                        res_active = slot_rdata.active;
                    end else begin
                        res_status = ghal_pkg::ST_STALE;
                    end
                end
                default: begin
                    res_status = ghal_pkg::ST_OK;
                end
            endcase
        end

        if (i_cmd.sweep_done) begin
            load      = 1'b1;
            res_freed = r_freed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw      <= '0;
            r_fc      <= '0;
            r_cnt     <= '0;
            r_freed   <= '0;
            r_live    <= '0;
            r_sw_v    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_hw    <= n_hw;
            r_fc    <= n_fc;
            r_cnt   <= n_cnt;
            r_freed <= n_freed;
            r_live  <= n_live;
            r_sw_v  <= sw_issue;
            if (load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr  <= slot_raddr;
        r_sw_idx <= r_cnt[ghal_pkg::IDX_W-1:0];
        if (i_cmd.accept) begin
            r_op         <= in_op;
            r_act        <= in_act;
            r_idx        <= in_idx;
            r_ver        <= in_ver;
            r_kind       <= in_kind;
            r_idx_ok     <= (in_idx < r_hw);
            r_from_stack <= (r_fc != '0);
            r_full       <= (r_fc == '0) && (r_hw == ghal_pkg::HW_W'(ghal_pkg::SLOTS));
            r_s          <= r_hw[ghal_pkg::IDX_W-1:0];
        end else if (i_cmd.pop) begin
            r_s <= stk_rdata;
        end
        if (load) begin
            r_m_data <= {{ghal_pkg::M_PAD_W{1'b0}}, res_freed, res_active,
                         res_version, res_index};
            r_m_user <= res_status;
        end
    end

    assign o_stat.stack_empty = (r_fc == '0);
    assign o_stat.sweep_end   = (r_cnt >= r_hw) && !r_sw_v;
    assign o_stat.out_free    = out_free;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    a_fc_le_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= r_hw)
        else $error("free stack deeper than high-water mark");

    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= ghal_pkg::HW_W'(ghal_pkg::SLOTS))
        else $error("high-water mark beyond table size");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sw_free |-> (r_fc < ghal_pkg::HW_W'(ghal_pkg::SLOTS)))
        else $error("free stack push with no room");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_fc != '0))
        else $error("free stack pop while empty");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_m_valid || i_m_tready))
        else $error("result register overwritten before it was taken");

endmodule

>>> rtl/generational_handle_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator
// handle table with versioned slots, lifo free stack and a tag-and-sweep free
// ----------------------------------------------------------------------------
// usage: one command word goes in on the s side, one result word comes out on
// the m side for every command. the opcode travels in s tuser, the status of
// the result in m tuser.
// a handle is (index, version); tag, activate, deactivate and query check
// that the index is below the high-water mark, the slot is live and the
// version matches, else they answer stale.
// steps: tag, activate, deactivate, query, full allocate and a fresh-slot
// allocate go from accept to an exec step that loads the result; an allocate
// that pops the free stack has a pop step first (stack read, then slot read).
// a sweep walks the slot ram one entry a cycle up to the high-water mark.
// only one command is in flight at a time; the next command is accepted
// right after the result is loaded into the output register, even while
// that result still waits for the receiver.
// stall: if the receiver holds tready low, the command in flight waits in
// its last step with no side effects until the output register frees up.
// reset: live bits, free count and high-water mark clear at once; the slot
// and stack rams need no clearing since no entry is read before written.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command word
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [0] start_active, [9:1] handle_index, [25:10] handle_version,
    // [27:26] destroy_kind, [31:28] zero
    input  logic [ghal_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // [2:0] op
    input  logic [ghal_pkg::S_TUSER_W-1:0]    i_s_tuser,
    // result word
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [7:0] out_index, [23:8] out_version, [24] active_flag,
    // [33:25] freed_count, [39:34] zero
    output logic [ghal_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // [1:0] status
    output logic [ghal_pkg::M_TUSER_W-1:0]    o_m_tuser
);

    ghal_pkg::t_cmd     cmd;
    ghal_pkg::t_dp_stat stat;

    // sequencer: picks the steps of each command from its opcode
    ghal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (ghal_pkg::t_op'(i_s_tuser[ghal_pkg::OP_W-1:0])),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    // datapath: slot ram, stack ram, live bits and the output register
    ghal_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cmd      (cmd),
        .i_m_tready (i_m_tready),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
